>>> rtl/core/rthsv_pkg.sv
// Shared constants and types for the RGB to HSV converter.
// Depends on nothing; imported by every module of the converter.
package rthsv_pkg;

   localparam int HUE_BITS   = 9;
   localparam int HUE_FULL   = 360;
   localparam int HUE_STEP   = 60;
   localparam int GREEN_BASE = 120;
   localparam int BLUE_BASE  = 240;

   typedef struct packed {
      logic hue_zero;   // grey pixel: all channels equal
      logic sat_zero;   // black pixel: largest channel is zero
   } flags_type;

endpackage

>>> rtl/core/rthsv_prep.sv
// Front end of the converter: max/min, hue sector, and the two dividends and divisors.
// Two register stages. Depends on rthsv_pkg.
module rthsv_prep
   import rthsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [CHANNEL_BITS-1:0]   in_red,
   input  logic [CHANNEL_BITS-1:0]   in_green,
   input  logic [CHANNEL_BITS-1:0]   in_blue,
   output logic                      out_valid,
   output logic [CHANNEL_BITS+9:0]   out_hue_num,
   output logic [CHANNEL_BITS:0]     out_hue_den,
   output logic [2*CHANNEL_BITS+1:0] out_sat_num,
   output logic [CHANNEL_BITS:0]     out_sat_den,
   output flags_type                 out_flags,
   output logic [CHANNEL_BITS-1:0]   out_val
);

   localparam int N  = CHANNEL_BITS;
   localparam int NW = N + 11;       // signed width of the hue numerator
   localparam int HW = N + 10;       // hue dividend width
   localparam int SW = 2 * N + 2;    // saturation dividend width

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // stage 1
   logic                  s1_vld_ff;
   logic [N-1:0]          s1_mx_ff, s1_mx_in;
   logic [N-1:0]          s1_mn_ff, s1_mn_in;
   sector_type            s1_sect_ff, s1_sect_in;
   logic signed [N:0]     s1_diff_ff, s1_diff_in;

   // stage 2
   logic                  s2_vld_ff;
   logic [HW-1:0]         s2_hnum_ff, s2_hnum_in;
   logic [N:0]            s2_hden_ff, s2_hden_in;
   logic [SW-1:0]         s2_snum_ff, s2_snum_in;
   logic [N:0]            s2_sden_ff, s2_sden_in;
   flags_type             s2_flags_ff, s2_flags_in;
   logic [N-1:0]          s2_val_ff;

   logic [N-1:0]          delta;
   logic [NW-1:0]         base;
   logic [NW-1:0]         num;

   // Largest channel decides the sector; red wins ties, then green.
   always_comb begin
      priority if (in_red >= in_green && in_red >= in_blue) begin
         s1_sect_in = SECT_RED;
         s1_mx_in   = in_red;
         s1_diff_in = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
      end else if (in_green >= in_blue) begin
         s1_sect_in = SECT_GREEN;
         s1_mx_in   = in_green;
         s1_diff_in = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
      end else begin
         s1_sect_in = SECT_BLUE;
         s1_mx_in   = in_blue;
         s1_diff_in = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
      end
      s1_mn_in = in_red;
      if (in_green < s1_mn_in) s1_mn_in = in_green;
      if (in_blue < s1_mn_in) s1_mn_in = in_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
      end
      s1_mx_ff   <= s1_mx_in;
      s1_mn_ff   <= s1_mn_in;
      s1_sect_ff <= s1_sect_in;
      s1_diff_ff <= s1_diff_in;
   end

   // Hue numerator is delta times the sector base angle plus 60*diff, always in [0, 360*delta).
   always_comb begin
      delta = s1_mx_ff - s1_mn_ff;
      unique case (s1_sect_ff)
         SECT_RED:   base = s1_diff_ff[N] ? NW'(delta) * NW'(HUE_FULL) : '0;
         SECT_GREEN: base = NW'(delta) * NW'(GREEN_BASE);
         SECT_BLUE:  base = NW'(delta) * NW'(BLUE_BASE);
         default:    base = '0;
      endcase
      num = base + NW'(s1_diff_ff) * NW'(HUE_STEP);

      // round half up: (2*num + den) / (2*den)
      s2_hnum_in = HW'(num << 1) + HW'(delta);
      s2_hden_in = {delta, 1'b0};
      s2_snum_in = (SW'(delta) << (N + 1)) - (SW'(delta) << 1) + SW'(s1_mx_ff);
      s2_sden_in = {s1_mx_ff, 1'b0};
      s2_flags_in.hue_zero = (delta == '0);
      s2_flags_in.sat_zero = (s1_mx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_hnum_ff  <= s2_hnum_in;
      s2_hden_ff  <= s2_hden_in;
      s2_snum_ff  <= s2_snum_in;
      s2_sden_ff  <= s2_sden_in;
      s2_flags_ff <= s2_flags_in;
      s2_val_ff   <= s1_mx_ff;
   end

   assign out_valid   = s2_vld_ff;
   assign out_hue_num = s2_hnum_ff;
   assign out_hue_den = s2_hden_ff;
   assign out_sat_num = s2_snum_ff;
   assign out_sat_den = s2_sden_ff;
   assign out_flags   = s2_flags_ff;
   assign out_val     = s2_val_ff;

endmodule

>>> rtl/core/rthsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with side data.
// Depends on rthsv_pkg only by convention; no shared items are used.
module rthsv_div
   import rthsv_pkg::*;
#(
   parameter int XW = 18,   // dividend width
   parameter int DW = 9,    // divisor width
   parameter int QW = 9,    // quotient width, quotient must stay below 2**QW
   parameter int TW = 1     // side data width
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [XW-1:0] in_dividend,
   input  logic [DW-1:0] in_divisor,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [TW-1:0] out_tag
);

   localparam int IW = (XW > DW + QW - 1) ? XW : DW + QW - 1;

   logic          vld_ff  [QW];
   logic [IW-1:0] rem_ff  [QW];
   logic [IW-1:0] rem_in  [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [QW-1:0] quot_in [QW];
   logic [DW-1:0] div_ff  [QW];
   logic [TW-1:0] tag_ff  [QW];

   logic          vld_prev  [QW];
   logic [IW-1:0] rem_prev  [QW];
   logic [QW-1:0] quot_prev [QW];
   logic [DW-1:0] div_prev  [QW];
   logic [TW-1:0] tag_prev  [QW];
   logic [IW-1:0] trial     [QW];

   always_comb begin
      vld_prev[0]  = in_valid;
      rem_prev[0]  = IW'(in_dividend);
      quot_prev[0] = '0;
      div_prev[0]  = in_divisor;
      tag_prev[0]  = in_tag;
      for (int k = 1; k < QW; k++) begin
         vld_prev[k]  = vld_ff[k-1];
         rem_prev[k]  = rem_ff[k-1];
         quot_prev[k] = quot_ff[k-1];
         div_prev[k]  = div_ff[k-1];
         tag_prev[k]  = tag_ff[k-1];
      end
      // stage k settles quotient bit QW-1-k
      for (int k = 0; k < QW; k++) begin
         trial[k] = IW'(div_prev[k]) << (QW - 1 - k);
         if (rem_prev[k] >= trial[k]) begin
            rem_in[k]  = rem_prev[k] - trial[k];
            quot_in[k] = quot_prev[k] | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_in[k]  = rem_prev[k];
            quot_in[k] = quot_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev[k];
         end
         rem_ff[k]  <= rem_in[k];
         quot_ff[k] <= quot_in[k];
         div_ff[k]  <= div_prev[k];
         tag_ff[k]  <= tag_prev[k];
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

>>> rtl/core/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front end, two dividers, output register.
// Depends on rthsv_pkg, rthsv_prep and rthsv_div.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------------
//   request | req_red_in, req_green_in, req_blue_in   | start while busy is low
//   result  | rsp_hue_out, rsp_sat_out, rsp_val_out   | rsp_strobe, one cycle
//
// One item is taken every cycle; busy never rises.
// Each item passes through two front-end stages, one divider stage per quotient bit,
// and the output register.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing is held back.
module rgb_to_hsv_converter
   import rthsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CHANNEL_BITS-1:0] req_red_in,
   input  logic [CHANNEL_BITS-1:0] req_green_in,
   input  logic [CHANNEL_BITS-1:0] req_blue_in,
   output logic                    rsp_strobe,
   output logic [HUE_BITS-1:0]     rsp_hue_out,
   output logic [CHANNEL_BITS-1:0] rsp_sat_out,
   output logic [CHANNEL_BITS-1:0] rsp_val_out
);

   localparam int N = CHANNEL_BITS;
   localparam int Q = (N > HUE_BITS) ? N : HUE_BITS;

   logic              prep_vld;
   logic [N+9:0]      prep_hnum;
   logic [N:0]        prep_hden;
   logic [2*N+1:0]    prep_snum;
   logic [N:0]        prep_sden;
   flags_type         prep_flags;
   logic [N-1:0]      prep_val;

   logic              hdiv_vld;
   logic [Q-1:0]      hdiv_quot;
   logic              hdiv_zero;
   logic              sdiv_vld;
   logic [Q-1:0]      sdiv_quot;
   logic [N:0]        sdiv_tag;

   logic                rsp_vld_ff, rsp_vld_in;
   logic [HUE_BITS-1:0] rsp_hue_ff, rsp_hue_in;
   logic [N-1:0]        rsp_sat_ff, rsp_sat_in;
   logic [N-1:0]        rsp_val_ff, rsp_val_in;

   assign busy = 1'b0;

   rthsv_prep #(
      .CHANNEL_BITS (N)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .in_red      (req_red_in),
      .in_green    (req_green_in),
      .in_blue     (req_blue_in),
      .out_valid   (prep_vld),
      .out_hue_num (prep_hnum),
      .out_hue_den (prep_hden),
      .out_sat_num (prep_snum),
      .out_sat_den (prep_sden),
      .out_flags   (prep_flags),
      .out_val     (prep_val)
   );

   rthsv_div #(
      .XW (N + 10),
      .DW (N + 1),
      .QW (Q),
      .TW (1)
   ) u_hue_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (prep_vld),
      .in_dividend (prep_hnum),
      .in_divisor  (prep_hden),
      .in_tag      (prep_flags.hue_zero),
      .out_valid   (hdiv_vld),
      .out_quot    (hdiv_quot),
      .out_tag     (hdiv_zero)
   );

   rthsv_div #(
      .XW (2 * N + 2),
      .DW (N + 1),
      .QW (Q),
      .TW (N + 1)
   ) u_sat_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (prep_vld),
      .in_dividend (prep_snum),
      .in_divisor  (prep_sden),
      .in_tag      ({prep_flags.sat_zero, prep_val}),
      .out_valid   (sdiv_vld),
      .out_quot    (sdiv_quot),
      .out_tag     (sdiv_tag)
   );

   // Force grey and black pixels, wrap a rounded full circle to zero.
   always_comb begin
      rsp_vld_in = hdiv_vld & sdiv_vld;
      if (hdiv_zero || hdiv_quot == Q'(HUE_FULL)) begin
         rsp_hue_in = '0;
      end else begin
         rsp_hue_in = hdiv_quot[HUE_BITS-1:0];
      end
      rsp_sat_in = sdiv_tag[N] ? '0 : sdiv_quot[N-1:0];
      rsp_val_in = sdiv_tag[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_hue_ff <= rsp_hue_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_strobe  = rsp_vld_ff;
   assign rsp_hue_out = rsp_hue_ff;
   assign rsp_sat_out = rsp_sat_ff;
   assign rsp_val_out = rsp_val_ff;

endmodule
